// ----- sv/tlbf_pkg.sv -----
// Shared types, constants and a helper function for the two-level bitmap.
package tlbf_pkg;

  localparam int INDEX_W     = 12;    // width of a bit position
  localparam int CFG_W       = 13;    // width of the positions-in-use register
  localparam int SUM_W       = 13;    // internal width for position arithmetic
  localparam int CFG_RESET   = 4096;  // positions in use after reset
  localparam int RECIP_SHIFT = 24;    // fraction bits of the word-size reciprocal

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_FIND   = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  typedef struct packed {
    logic               status;
    logic               found;
    logic [INDEX_W-1:0] position;
    logic               empty_res;
  } result_t;

  typedef struct packed {
    logic wr;   // write one word
    logic clr;  // empty every word
  } store_ctl_t;

  // Count trailing zeros by halving; meaningful for a non-zero word only
  function automatic logic [5:0] ctz64(input logic [63:0] v);
    logic [63:0] x;
    logic [5:0]  n;
    x = v;
    n = '0;
    for (int k = 5; k >= 0; k--) begin
      if ((x & ((64'd1 << (1 << k)) - 64'd1)) == 64'd0) begin
        n[k] = 1'b1;
        x    = x >> (1 << k);
      end
    end
    return n;
  endfunction

endpackage

// ----- sv/tlbf_req_if.sv -----
// Request channel: one action with its bit position.
interface tlbf_req_if;
  logic                            valid;
  logic                            ready;
  tlbf_pkg::action_t               action;
  logic [tlbf_pkg::INDEX_W-1:0]    index;

  modport source (output valid, output action, output index, input ready);
  modport sink   (input valid, input action, input index, output ready);
endinterface

// ----- sv/tlbf_res_if.sv -----
// Result channel: status, search outcome and emptiness of the set.
interface tlbf_res_if;
  logic                            valid;
  logic                            ready;
  logic                            status;
  logic                            found;
  logic [tlbf_pkg::INDEX_W-1:0]    position;
  logic                            empty_res;

  modport source (output valid, output status, output found, output position,
                  output empty_res, input ready);
  modport sink   (input valid, input status, input found, input position,
                  input empty_res, output ready);
endinterface

// ----- sv/tlbf_store.sv -----
// Word store: two registered read ports, one write port, per-word valid bits.
module tlbf_store #(
  parameter int WORD_BITS  = 64,
  parameter int WORD_COUNT = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   rd_en,
  input  logic [((WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1)-1:0] rd_addr_a,
  input  logic [((WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1)-1:0] rd_addr_b,
  input  tlbf_pkg::store_ctl_t   ctl,
  input  logic [((WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1)-1:0] wr_addr,
  input  logic [WORD_BITS-1:0]   wr_data,
  output logic [WORD_BITS-1:0]   rd_data_a,
  output logic [WORD_BITS-1:0]   rd_data_b
);

  logic [WORD_BITS-1:0]  mem [WORD_COUNT];
  logic [WORD_COUNT-1:0] vld;

  logic [WORD_BITS-1:0]  raw_a;
  logic [WORD_BITS-1:0]  raw_b;
  logic [WORD_BITS-1:0]  fwd_data;
  logic                  hit_a;
  logic                  hit_b;
  logic                  zero_a;
  logic                  zero_b;

  logic                  wr_hit_a;
  logic                  wr_hit_b;

  assign wr_hit_a = ctl.wr && (wr_addr == rd_addr_a);
  assign wr_hit_b = ctl.wr && (wr_addr == rd_addr_b);

  // Write one word, read two; keep the word being written for bypass
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      raw_a    <= mem[rd_addr_a];
      raw_b    <= mem[rd_addr_b];
      fwd_data <= wr_data;
      hit_a    <= wr_hit_a;
      hit_b    <= wr_hit_b;
      zero_a   <= ctl.clr || (!vld[rd_addr_a] && !wr_hit_a);
      zero_b   <= ctl.clr || (!vld[rd_addr_b] && !wr_hit_b);
    end
  end

  // Mark written words; drop every mark on reset or clear
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ctl.clr) begin
      vld <= '0;
    end else if (ctl.wr) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // An unwritten word reads as zero; a same-edge write is bypassed
  assign rd_data_a = zero_a ? '0 : (hit_a ? fwd_data : raw_a);
  assign rd_data_b = zero_b ? '0 : (hit_b ? fwd_data : raw_b);

endmodule

// ----- sv/tlbf_exec.sv -----
// Action evaluation: bounds check, word update, summary update and search.
module tlbf_exec #(
  parameter int WORD_BITS  = 64,
  parameter int WORD_COUNT = 64
) (
  input  tlbf_pkg::action_t              action,
  input  logic [tlbf_pkg::INDEX_W-1:0]   index,
  input  logic [$clog2(((2**tlbf_pkg::INDEX_W) - 1) / WORD_BITS + 1)-1:0] w,
  input  logic [$clog2(WORD_COUNT + 1)-1:0] words,
  input  logic [((WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1)-1:0] nw,
  input  logic                           above_nz,
  input  logic [WORD_BITS-1:0]           word_a,
  input  logic [WORD_BITS-1:0]           word_b,
  input  logic [WORD_COUNT-1:0]          summary,
  output tlbf_pkg::result_t              res,
  output tlbf_pkg::store_ctl_t           ctl,
  output logic [((WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1)-1:0] wr_addr,
  output logic [WORD_BITS-1:0]           wr_data,
  output logic [WORD_COUNT-1:0]          summary_next
);

  localparam int A_W   = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int OFF_W = $clog2(WORD_BITS);
  localparam int SW    = tlbf_pkg::SUM_W;

  logic              in_range;
  logic [A_W-1:0]    wa;
  logic [SW-1:0]     base;
  logic [SW-1:0]     off_full;
  logic [OFF_W-1:0]  off;
  logic [WORD_BITS-1:0] bit_sel;
  logic [WORD_BITS-1:0] low_mask;
  logic [WORD_BITS-1:0] masked;
  logic [WORD_BITS-1:0] set_word;
  logic [WORD_BITS-1:0] clr_word;
  logic [5:0]        ctz_a;
  logic [5:0]        ctz_b;
  logic [SW-1:0]     near_pos;
  logic [SW-1:0]     far_pos;

  // Split the position into word and offset
  assign in_range = SW'(w) < SW'(words);
  assign wa       = w[A_W-1:0];
  assign base     = SW'(w) * SW'(WORD_BITS);
  assign off_full = SW'(index) - base;
  assign off      = off_full[OFF_W-1:0];

  assign bit_sel  = WORD_BITS'(1) << off;
  assign low_mask = bit_sel - WORD_BITS'(1);
  assign masked   = word_a & ~low_mask;
  assign set_word = word_a | bit_sel;
  assign clr_word = word_a & ~bit_sel;

  // Candidate hits: in the start word, or in the next non-empty word
  assign ctz_a    = tlbf_pkg::ctz64(64'(masked));
  assign ctz_b    = tlbf_pkg::ctz64(64'(word_b));
  assign near_pos = base + SW'(ctz_a);
  assign far_pos  = SW'(nw) * SW'(WORD_BITS) + SW'(ctz_b);

  always_comb begin
    res          = '0;
    ctl          = '0;
    wr_addr      = wa;
    wr_data      = set_word;
    summary_next = summary;
    case (action)
      tlbf_pkg::ACT_CLEAR: begin
        ctl.clr      = 1'b1;
        summary_next = '0;
      end
      tlbf_pkg::ACT_INSERT: begin
        if (in_range) begin
          ctl.wr           = 1'b1;
          wr_data          = set_word;
          summary_next[wa] = 1'b1;
        end else begin
          res.status = tlbf_pkg::STATUS_BAD;
        end
      end
      tlbf_pkg::ACT_REMOVE: begin
        if (in_range) begin
          ctl.wr  = 1'b1;
          wr_data = clr_word;
          if (clr_word == '0) begin
            summary_next[wa] = 1'b0;
          end
        end else begin
          res.status = tlbf_pkg::STATUS_BAD;
        end
      end
      tlbf_pkg::ACT_FIND: begin
        if (!in_range) begin
          res.status = tlbf_pkg::STATUS_BAD;
        end else if (masked != '0) begin
          res.found    = 1'b1;
          res.position = near_pos[tlbf_pkg::INDEX_W-1:0];
        end else if (above_nz && (word_b != '0)) begin
          res.found    = 1'b1;
          res.position = far_pos[tlbf_pkg::INDEX_W-1:0];
        end
      end
      default: begin
        res = '0;
      end
    endcase
    res.empty_res = (summary_next == '0);
  end

endmodule

// ----- sv/two_level_bitmap_find_next.sv -----
// Two-level bitmap with next-set-bit search over a 64-word store.
// The request is registered in the input stage, and its result then in the result register.
// Throughput: one request per cycle while the result register is free; the start word and the next non-empty word
//   come from the two read ports of the word store, updated in the same cycle.
// Reset (rst, synchronous): empties the set at once through per-word valid bits,
//   clears the summary and restores 4096 positions in use; no clearing pass.
module two_level_bitmap_find_next #(
  parameter int WORD_BITS  = 64,
  parameter int WORD_COUNT = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [tlbf_pkg::CFG_W-1:0]   cfg_wdata,
  tlbf_req_if.sink                     req,
  tlbf_res_if.source                   res
);

  localparam int A_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int CNT_W   = $clog2(WORD_COUNT + 1);
  localparam int Q_W     = $clog2(((2**tlbf_pkg::INDEX_W) - 1) / WORD_BITS + 1);
  localparam int SW      = tlbf_pkg::SUM_W;
  localparam int SHIFT   = tlbf_pkg::RECIP_SHIFT;
  localparam int RECIP   = ((2**SHIFT) + WORD_BITS - 1) / WORD_BITS;
  localparam int IPROD_W = SHIFT + Q_W + 1;
  localparam int CQ_W    = tlbf_pkg::CFG_W + 1;
  localparam int CPROD_W = SHIFT + CQ_W + 1;
  localparam int RW_RAW  = (tlbf_pkg::CFG_RESET + WORD_BITS - 1) / WORD_BITS;
  localparam int RESET_WORDS = (RW_RAW > WORD_COUNT) ? WORD_COUNT : RW_RAW;

  // Input stage
  logic                       s1_valid;
  tlbf_pkg::action_t          s1_action;
  logic [tlbf_pkg::INDEX_W-1:0] s1_index;
  logic [Q_W-1:0]             s1_w;
  logic [A_W-1:0]             s1_nw;
  logic                       s1_above_nz;

  // Set state
  logic [WORD_COUNT-1:0]      summary;
  logic [CNT_W-1:0]           words;
  logic [CNT_W-1:0]           words_next;

  // Result register
  logic                       out_valid;
  tlbf_pkg::result_t          out_data;

  logic                       accept;
  logic                       advance;

  logic [IPROD_W-1:0]         in_prod;
  logic [Q_W-1:0]             w_in;
  logic [WORD_COUNT-1:0]      summary_eff;
  logic [WORD_COUNT-1:0]      above_in;
  logic [5:0]                 nw_full;
  logic [A_W-1:0]             nw_in;

  logic [CQ_W-1:0]            cfg_sum;
  logic [CPROD_W-1:0]         cfg_prod;
  logic [CQ_W-1:0]            cfg_q;

  logic [WORD_BITS-1:0]       word_a;
  logic [WORD_BITS-1:0]       word_b;
  tlbf_pkg::result_t          ex_res;
  tlbf_pkg::store_ctl_t       ex_ctl;
  tlbf_pkg::store_ctl_t       st_ctl;
  logic [A_W-1:0]             wr_addr;
  logic [WORD_BITS-1:0]       wr_data;
  logic [WORD_COUNT-1:0]      summary_next;

  // Handshake: the input stage moves on when the result register is free
  assign advance   = s1_valid && (!out_valid || res.ready);
  assign req.ready = !s1_valid || advance;
  assign accept    = req.valid && req.ready;

  // Word number of the incoming position by reciprocal multiply
  assign in_prod = IPROD_W'(req.index) * IPROD_W'(RECIP);
  assign w_in    = in_prod[SHIFT +: Q_W];

  // Non-empty words wholly above the incoming position, seen after the
  // update of the item now leaving the input stage
  assign summary_eff = advance ? summary_next : summary;

  always_comb begin
    for (int j = 0; j < WORD_COUNT; j++) begin
      above_in[j] = summary_eff[j] &&
                    (SW'(j * WORD_BITS) > SW'(req.index));
    end
  end

  assign nw_full = tlbf_pkg::ctz64(64'(above_in));
  assign nw_in   = nw_full[A_W-1:0];

  // Words in use: ceiling of the written count, limited to the store depth
  assign cfg_sum    = CQ_W'(cfg_wdata) + CQ_W'(WORD_BITS - 1);
  assign cfg_prod   = CPROD_W'(cfg_sum) * CPROD_W'(RECIP);
  assign cfg_q      = cfg_prod[SHIFT +: CQ_W];
  assign words_next = (cfg_q > CQ_W'(WORD_COUNT)) ? CNT_W'(WORD_COUNT) : cfg_q[CNT_W-1:0];

  // Input stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // Input stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_action   <= req.action;
      s1_index    <= req.index;
      s1_w        <= w_in;
      s1_nw       <= nw_in;
      s1_above_nz <= |above_in;
    end
  end

  // Summary and words in use; a register write also empties the set
  always_ff @(posedge clk) begin
    if (rst) begin
      summary <= '0;
      words   <= CNT_W'(RESET_WORDS);
    end else if (cfg_we) begin
      summary <= '0;
      words   <= words_next;
    end else if (advance) begin
      summary <= summary_next;
    end
  end

  assign st_ctl.wr  = advance && ex_ctl.wr;
  assign st_ctl.clr = (advance && ex_ctl.clr) || cfg_we;

  tlbf_store #(
    .WORD_BITS  (WORD_BITS),
    .WORD_COUNT (WORD_COUNT)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .rd_addr_a (w_in[A_W-1:0]),
    .rd_addr_b (nw_in),
    .ctl       (st_ctl),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_data_a (word_a),
    .rd_data_b (word_b)
  );

  tlbf_exec #(
    .WORD_BITS  (WORD_BITS),
    .WORD_COUNT (WORD_COUNT)
  ) u_exec (
    .action       (s1_action),
    .index        (s1_index),
    .w            (s1_w),
    .words        (words),
    .nw           (s1_nw),
    .above_nz     (s1_above_nz),
    .word_a       (word_a),
    .word_b       (word_b),
    .summary      (summary),
    .res          (ex_res),
    .ctl          (ex_ctl),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .summary_next (summary_next)
  );

  // Result register valid: load on advance, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= ex_res;
    end
  end

  assign res.valid     = out_valid;
  assign res.status    = out_data.status;
  assign res.found     = out_data.found;
  assign res.position  = out_data.position;
  assign res.empty_res = out_data.empty_res;

`ifndef SYNTHESIS
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (advance && (s1_action == tlbf_pkg::ACT_CLEAR)) |=> (summary == '0))
    else $error("summary not empty after clear");

  a_cfg_empties: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> (summary == '0))
    else $error("summary not empty after register write");

  a_insert_marks: assert property (@(posedge clk) disable iff (rst)
    (advance && (s1_action == tlbf_pkg::ACT_INSERT) &&
     (ex_res.status == tlbf_pkg::STATUS_OK)) |=> (summary != '0))
    else $error("summary empty after accepted insert");

  a_bad_not_found: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !(res.status && res.found))
    else $error("rejected result reports a hit");
`endif

endmodule
